// File: design/resp_request_parser_unit_defines.svh
// Assertion macros for the request parser unit.
// Used by the top level; no other dependencies.
`ifndef RESP_REQUEST_PARSER_UNIT_DEFINES_SVH
`define RESP_REQUEST_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define RRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RRP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define RRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RRP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: design/rrp_pkg.sv
// Shared types and constants for the request parser unit.
// No dependencies; imported by every module of the block.
package rrp_pkg;

    localparam int COUNT_BITS = 31;
    localparam int IDX_W      = 31;
    localparam int MAX_RES    = 3;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [63:0] LIM_CNT     = 64'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [63:0] LIM_CNT_NEG = 64'd1;
    localparam logic [63:0] LIM_INT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_INT_NEG = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_EEND = 2'd1;
    localparam logic [1:0] KIND_INT  = 2'd2;
    localparam logic [1:0] KIND_MEND = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_NUMBER  = 3'd1;
    localparam logic [2:0] ST_UNTERM      = 3'd2;
    localparam logic [2:0] ST_BULK_SHORT  = 3'd3;
    localparam logic [2:0] ST_MISSING     = 3'd4;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } t_slot;

    typedef struct packed {
        logic [1:0]               n;
        t_slot [MAX_RES-1:0]      slot;
        logic [63:0]              ival;
        logic [2:0]               status;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/rrp_front.sv
// Front end: accepts message beats, runs the parse state machine and
// packs the results of each beat into one bundle. Depends on rrp_pkg.
module rrp_front import rrp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    [7:0] i_byte,
    input  logic    i_last,
    input  t_q_stat i_q_stat,
    output logic    o_stall,
    output logic    o_push,
    output t_bundle o_bundle
);

    typedef enum logic [3:0] {
        M_START, M_INLINE, M_HDR, M_TYPE, M_BLEN, M_BDATA,
        M_SKIP, M_INUM, M_LINE, M_DONE, M_ERR
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [63:0]           r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_dig, n_dig;
    logic [COUNT_BITS-1:0] r_eleft, n_eleft;
    logic [COUNT_BITS-1:0] r_blen, n_blen;
    logic [1:0]            r_skip, n_skip;
    logic                  r_hcr, n_hcr;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic [2:0]            r_err, n_err;
    logic                  r_tok, n_tok;

    logic        is_count;
    logic [63:0] limit;
    logic [3:0]  dig4;
    logic [63:0] lim_y;
    logic [67:0] prod;
    logic        nb_done, nb_err;
    logic [63:0] nb_acc;
    logic        nb_neg, nb_dig, nb_hcr;

    logic        accept;
    logic        consumed;
    logic        do_close;
    t_mode       close_next;
    logic [1:0]  nr;
    logic [2:0]  st;
    t_bundle     bun;

    assign accept   = i_valid && !i_q_stat.full;
    assign o_stall  = i_q_stat.full;
    assign o_push   = accept && (nr != 2'd0);
    assign o_bundle = bun;

    // number digit step
    always_comb begin
        is_count = (r_mode == M_HDR) || (r_mode == M_BLEN);
        if (is_count) begin
            limit = r_neg ? LIM_CNT_NEG : LIM_CNT;
        end else begin
            limit = r_neg ? LIM_INT_NEG : LIM_INT_POS;
        end
        dig4    = 4'(i_byte - CH_0);
        lim_y   = limit - {60'd0, dig4};
        prod    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
        nb_done = 1'b0;
        nb_err  = 1'b0;
        nb_acc  = r_acc;
        nb_neg  = r_neg;
        nb_dig  = r_dig;
        nb_hcr  = r_hcr;
        if (r_hcr) begin
            nb_hcr = 1'b0;
            if (i_byte == CH_LF && r_dig) begin
                nb_done = 1'b1;
            end else begin
                nb_err = 1'b1;
            end
        end else if (i_byte == CH_CR) begin
            nb_hcr = 1'b1;
        end else if (i_byte == CH_MINUS && !r_dig && !r_neg) begin
            nb_neg = 1'b1;
        end else if (i_byte >= CH_0 && i_byte <= CH_9) begin
            if (prod > {4'd0, lim_y}) begin
                nb_err = 1'b1;
            end else begin
                nb_acc = prod[63:0] + {60'd0, dig4};
                nb_dig = 1'b1;
            end
        end else begin
            nb_err = 1'b1;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_dig      = r_dig;
        n_eleft    = r_eleft;
        n_blen     = r_blen;
        n_skip     = r_skip;
        n_hcr      = r_hcr;
        n_cnt      = r_cnt;
        n_err      = r_err;
        n_tok      = r_tok;
        bun        = '0;
        nr         = 2'd0;
        consumed   = 1'b0;
        do_close   = 1'b0;
        close_next = M_TYPE;
        st         = ST_OK;

        if (r_mode == M_START) begin
            if (i_byte == CH_STAR) begin
                n_mode   = M_HDR;
                n_acc    = '0;
                n_neg    = 1'b0;
                n_dig    = 1'b0;
                n_hcr    = 1'b0;
                consumed = 1'b1;
            end else begin
                n_mode = M_INLINE;
            end
        end

        if (!consumed) begin
            case (n_mode)
                M_INLINE: begin
                    if (i_byte == CH_SPACE || (i_byte >= CH_TAB && i_byte <= CH_CR)) begin
                        if (r_tok) begin
                            bun.slot[nr] = '{kind: KIND_EEND, data: 8'd0, idx: n_cnt};
                            nr           = nr + 2'd1;
                            n_cnt        = n_cnt + 1'b1;
                            n_tok        = 1'b0;
                        end
                    end else begin
                        bun.slot[nr] = '{kind: KIND_BYTE, data: i_byte, idx: n_cnt};
                        nr           = nr + 2'd1;
                        n_tok        = 1'b1;
                    end
                end
                M_HDR: begin
                    n_acc = nb_acc;
                    n_neg = nb_neg;
                    n_dig = nb_dig;
                    n_hcr = nb_hcr;
                    if (nb_err) begin
                        n_err  = ST_BAD_NUMBER;
                        n_mode = M_ERR;
                    end else if (nb_done) begin
                        n_eleft = nb_neg ? '0 : nb_acc[COUNT_BITS-1:0];
                        n_mode  = (n_eleft != '0) ? M_TYPE : M_DONE;
                    end
                end
                M_TYPE: begin
                    if (i_byte == CH_DOLLAR || i_byte == CH_COLON) begin
                        n_mode = (i_byte == CH_DOLLAR) ? M_BLEN : M_INUM;
                        n_acc  = '0;
                        n_neg  = 1'b0;
                        n_dig  = 1'b0;
                        n_hcr  = 1'b0;
                    end else if (i_byte == CH_PLUS) begin
                        n_mode = M_LINE;
                        n_hcr  = 1'b0;
                    end else begin
                        n_err  = ST_UNSUPPORTED;
                        n_mode = M_ERR;
                    end
                end
                M_BLEN: begin
                    n_acc = nb_acc;
                    n_neg = nb_neg;
                    n_dig = nb_dig;
                    n_hcr = nb_hcr;
                    if (nb_err) begin
                        n_err  = ST_BAD_NUMBER;
                        n_mode = M_ERR;
                    end else if (nb_done) begin
                        if (nb_neg || nb_acc == '0) begin
                            bun.slot[nr] = '{kind: KIND_EEND, data: 8'd0, idx: n_cnt};
                            nr           = nr + 2'd1;
                            do_close     = 1'b1;
                            close_next   = nb_neg ? M_TYPE : M_SKIP;
                        end else begin
                            n_blen = nb_acc[COUNT_BITS-1:0];
                            n_mode = M_BDATA;
                        end
                    end
                end
                M_BDATA: begin
                    bun.slot[nr] = '{kind: KIND_BYTE, data: i_byte, idx: n_cnt};
                    nr           = nr + 2'd1;
                    n_blen       = r_blen - 1'b1;
                    if (n_blen == '0) begin
                        bun.slot[nr] = '{kind: KIND_EEND, data: 8'd0, idx: n_cnt};
                        nr           = nr + 2'd1;
                        do_close     = 1'b1;
                        close_next   = M_SKIP;
                    end
                end
                M_SKIP: begin
                    n_skip = r_skip - 2'd1;
                    if (n_skip == 2'd0) begin
                        n_mode = M_TYPE;
                    end
                end
                M_INUM: begin
                    n_acc = nb_acc;
                    n_neg = nb_neg;
                    n_dig = nb_dig;
                    n_hcr = nb_hcr;
                    if (nb_err) begin
                        n_err  = ST_BAD_NUMBER;
                        n_mode = M_ERR;
                    end else if (nb_done) begin
                        bun.slot[nr] = '{kind: KIND_INT, data: 8'd0, idx: n_cnt};
                        nr           = nr + 2'd1;
                        bun.ival     = nb_neg ? (64'd0 - nb_acc) : nb_acc;
                        do_close     = 1'b1;
                        close_next   = M_TYPE;
                    end
                end
                M_LINE: begin
                    if (r_hcr) begin
                        if (i_byte == CH_LF) begin
                            n_hcr        = 1'b0;
                            bun.slot[nr] = '{kind: KIND_EEND, data: 8'd0, idx: n_cnt};
                            nr           = nr + 2'd1;
                            do_close     = 1'b1;
                            close_next   = M_TYPE;
                        end else if (i_byte == CH_CR) begin
                            bun.slot[nr] = '{kind: KIND_BYTE, data: CH_CR, idx: n_cnt};
                            nr           = nr + 2'd1;
                        end else begin
                            bun.slot[nr] = '{kind: KIND_BYTE, data: CH_CR, idx: n_cnt};
                            nr           = nr + 2'd1;
                            bun.slot[nr] = '{kind: KIND_BYTE, data: i_byte, idx: n_cnt};
                            nr           = nr + 2'd1;
                            n_hcr        = 1'b0;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_hcr = 1'b1;
                    end else begin
                        bun.slot[nr] = '{kind: KIND_BYTE, data: i_byte, idx: n_cnt};
                        nr           = nr + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_close) begin
            n_cnt   = n_cnt + 1'b1;
            n_eleft = n_eleft - 1'b1;
            n_mode  = (n_eleft != '0) ? close_next : M_DONE;
            if (n_mode == M_SKIP) begin
                n_skip = 2'd2;
            end
        end

        if (i_last) begin
            st = n_err;
            if (st == ST_OK) begin
                case (n_mode)
                    M_INLINE: begin
                        if (n_tok) begin
                            bun.slot[nr] = '{kind: KIND_EEND, data: 8'd0, idx: n_cnt};
                            nr           = nr + 2'd1;
                            n_cnt        = n_cnt + 1'b1;
                        end
                    end
                    M_HDR, M_BLEN, M_INUM, M_LINE: st = ST_UNTERM;
                    M_BDATA:                       st = ST_BULK_SHORT;
                    M_TYPE, M_SKIP:                st = ST_MISSING;
                    default: begin
                    end
                endcase
            end
            bun.slot[nr] = '{kind: KIND_MEND, data: 8'd0, idx: n_cnt};
            nr           = nr + 2'd1;
            bun.status   = st;
            n_mode       = M_START;
            n_acc        = '0;
            n_neg        = 1'b0;
            n_dig        = 1'b0;
            n_eleft      = '0;
            n_blen       = '0;
            n_skip       = 2'd0;
            n_hcr        = 1'b0;
            n_cnt        = '0;
            n_err        = ST_OK;
            n_tok        = 1'b0;
        end
        bun.n = nr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
            r_eleft <= '0;
            r_blen  <= '0;
            r_skip  <= 2'd0;
            r_hcr   <= 1'b0;
            r_cnt   <= '0;
            r_err   <= ST_OK;
            r_tok   <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_dig   <= n_dig;
            r_eleft <= n_eleft;
            r_blen  <= n_blen;
            r_skip  <= n_skip;
            r_hcr   <= n_hcr;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_tok   <= n_tok;
        end
    end

endmodule

// File: design/rrp_fifo.sv
// Short bundle queue between the parser front end and the result back end.
// Depends on rrp_pkg.
module rrp_fifo import rrp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_head,
    output t_q_stat o_stat
);

    t_bundle          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/rrp_back.sv
// Back end: walks the queued bundles and drives one result beat per cycle, unless
// i_stall holds it, through the output register. Depends on rrp_pkg.
module rrp_back import rrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bundle          i_head,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte,
    output logic [63:0]      o_int,
    output logic [IDX_W-1:0] o_idx,
    output logic [2:0]       o_status,
    output logic             o_run_last
);

    logic             r_valid;
    logic [1:0]       r_slot;
    logic [1:0]       r_kind;
    logic [7:0]       r_byte;
    logic [63:0]      r_int;
    logic [IDX_W-1:0] r_idx;
    logic [2:0]       r_status;
    logic             r_run_last;

    logic  load;
    logic  last_slot;
    t_slot cur;

    assign cur       = i_head.slot[r_slot];
    assign last_slot = (r_slot == (i_head.n - 2'd1));
    assign load      = (!r_valid || !i_stall) && !i_q_stat.empty;
    assign o_pop     = load && last_slot;

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_byte     = r_byte;
    assign o_int      = r_int;
    assign o_idx      = r_idx;
    assign o_status   = r_status;
    assign o_run_last = r_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 2'd0;
        end else if (load) begin
            r_valid    <= 1'b1;
            r_slot     <= last_slot ? 2'd0 : r_slot + 2'd1;
            r_kind     <= cur.kind;
            r_byte     <= (cur.kind == KIND_BYTE) ? cur.data : 8'd0;
            r_int      <= (cur.kind == KIND_INT) ? i_head.ival : 64'd0;
            r_idx      <= cur.idx;
            r_status   <= (cur.kind == KIND_MEND) ? i_head.status : ST_OK;
            r_run_last <= last_slot;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: design/resp_request_parser_unit.sv
// Path: an accepted input beat is written into the bundle queue, and its results then pass through the output register.
// Throughput: one input beat per cycle while the queue is not full, and the back end
// drains one result per cycle unless stalled; a beat with two or three results holds
// the back end for each of them, and the four-bundle queue stalls the input once full.
// Reset: synchronous active-low i_rst_n clears parser state, queue and output valid.
`include "resp_request_parser_unit_defines.svh"
module resp_request_parser_unit import rrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [63:0]      o_out_int,
    output logic [IDX_W-1:0] o_elem_index,
    output logic [2:0]       o_status,
    output logic             o_run_last
);

    t_q_stat q_stat;
    t_bundle push_data;
    t_bundle head;
    logic    push;
    logic    pop;

    rrp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .i_q_stat (q_stat),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_bundle (push_data)
    );

    rrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    rrp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_kind     (o_out_kind),
        .o_byte     (o_out_byte),
        .o_int      (o_out_int),
        .o_idx      (o_elem_index),
        .o_status   (o_status),
        .o_run_last (o_run_last)
    );

    `RRP_ASSERT_IMP(a_mend_run_last, i_clk, i_rst_n, o_out_valid && o_out_kind == KIND_MEND, o_run_last)
    `RRP_ASSERT_IMP(a_status_only_mend, i_clk, i_rst_n, o_out_valid && o_out_kind != KIND_MEND, o_status == ST_OK)
    `RRP_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, push && q_stat.full)
    `RRP_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && q_stat.empty)

endmodule
